// File: sv/nnue_accumulator_update_unit_defines.svh
// Assertion macros for the accumulator update unit.
`ifndef NNUE_ACCUMULATOR_UPDATE_UNIT_DEFINES_SVH
`define NNUE_ACCUMULATOR_UPDATE_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define NAU_ASSERT_IMP(lbl, clk_s, rstn_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (a) |-> (b)) \
    else $error("assertion failed");
`define NAU_ASSERT_NXT(lbl, clk_s, rstn_s, a, b) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (a) |=> (b)) \
    else $error("assertion failed");
`else
`define NAU_ASSERT_IMP(lbl, clk_s, rstn_s, a, b)
`define NAU_ASSERT_NXT(lbl, clk_s, rstn_s, a, b)
`endif
`endif

// File: sv/nau_pkg.sv
// Package with sizes, codes and types of the accumulator update unit.
package nau_pkg;
  localparam int ACC_LEN      = 1024;
  localparam int NUM_FEATURES = 768;
  localparam int LANES        = 16;   // must be a power of two
  localparam int WORDS        = ACC_LEN / LANES;
  localparam int WORD_W       = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LANE_W       = (LANES > 1) ? $clog2(LANES) : 1;
  // The bias vector is kept as one extra row after the last feature row.
  localparam int WADDR_W      = $clog2((NUM_FEATURES + 1) * WORDS);
  localparam int DW           = 16;
  localparam int VW           = LANES * DW;

  localparam logic [2:0] REQ_WR_WEIGHT = 3'd0;
  localparam logic [2:0] REQ_WR_BIAS   = 3'd1;
  localparam logic [2:0] REQ_LOAD_BIAS = 3'd2;
  localparam logic [2:0] REQ_ADD_ROW   = 3'd3;
  localparam logic [2:0] REQ_SUB_ROW   = 3'd4;
  localparam logic [2:0] REQ_MOVE      = 3'd5;
  localparam logic [2:0] REQ_READ      = 3'd6;

  localparam logic [1:0] MOVE_CAPTURE  = 2'd1;
  localparam logic [1:0] MOVE_CASTLE   = 2'd2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [9:0]  add_feature_1;
    logic [9:0]  add_feature_2;
    logic [9:0]  remove_feature_1;
    logic [9:0]  remove_feature_2;
    logic [1:0]  move_kind;
    logic [9:0]  element_index;
    logic signed [15:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] read_value;
    logic [2:0]  ack_type;
  } out_word_t;

  typedef struct packed {
    logic copy;
    logic sub;
  } alu_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_DRAIN, ST_FETCH, ST_DONE
  } state_t;
endpackage

// File: sv/nau_lane_alu.sv
// Lane-parallel add, subtract or bias copy for one accumulator word.
module nau_lane_alu import nau_pkg::*; (
  input  logic [VW-1:0] acc_word,
  input  logic [VW-1:0] weight_word,
  input  logic [VW-1:0] bias_word,
  input  alu_ctrl_t     ctrl,
  output logic [VW-1:0] new_word
);
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (ctrl.copy) begin
        new_word[l*DW +: DW] = bias_word[l*DW +: DW];
      end else if (ctrl.sub) begin
        new_word[l*DW +: DW] = acc_word[l*DW +: DW] - weight_word[l*DW +: DW];
      end else begin
        new_word[l*DW +: DW] = acc_word[l*DW +: DW] + weight_word[l*DW +: DW];
      end
    end
  end
endmodule

// File: sv/nnue_accumulator_update_unit.sv
// Top level of the accumulator update unit.
// A word is accepted when start is high and busy is low; each word gives one result word
// on out_data for a single cycle with out_valid, and the receiver cannot stall it. Weight and
// bias writes pass from idle straight to the done state, reads through a fetch state first. Bias loads and row
// updates sweep the accumulator memory one 16-lane word a cycle, all 64 words for each row
// applied, followed by a drain state of the read-modify-write pipe, and skip each of the four
// row slots left unused; an add or subtract of an absent row sweeps no word.
`include "nnue_accumulator_update_unit_defines.svh"
module nnue_accumulator_update_unit import nau_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_data,
  output logic      out_valid,
  output out_word_t out_data
);
  logic [VW-1:0] weight_mem [(NUM_FEATURES+1)*WORDS];
  logic [VW-1:0] acc_mem    [WORDS];
  logic [WORDS-1:0] acc_vld_r;

  state_t state_r, state_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [3:0]        slot_en_r, slot_en_nxt;
  logic [3:0]        slot_sub_r, slot_sub_nxt;
  logic [9:0]        slot_row_r [4];
  logic              copy_r;
  logic [LANE_W-1:0] lane_r;
  logic              elem_ok_r;
  out_word_t         res_r;

  logic              accept;
  logic [LANE_W-1:0] in_lane;
  logic [WORD_W-1:0] in_word;
  logic              in_elem_ok, in_row_ok;
  logic              issue;
  logic              w_we;
  logic [WORD_W-1:0] acc_raddr;
  logic [WADDR_W-1:0] w_raddr, w_waddr;

  logic              pv_r;
  logic [WORD_W-1:0] pw_r;
  alu_ctrl_t         pctl_r;
  logic [VW-1:0]     w_rd_r, a_rd_r;
  logic              a_rdv_r;
  logic [VW-1:0]     new_word;

  assign accept     = start && !busy;
  assign busy       = (state_r != ST_IDLE);
  assign in_lane    = LANE_W'(32'(in_data.element_index) % LANES);
  assign in_word    = WORD_W'(32'(in_data.element_index) / LANES);
  assign in_elem_ok = 32'(in_data.element_index) < ACC_LEN;
  assign in_row_ok  = 32'(in_data.add_feature_1) < NUM_FEATURES;
  assign acc_raddr  = (state_r == ST_IDLE) ? in_word : word_r;
  assign w_raddr    = WADDR_W'(32'(slot_row_r[slot_r]) * WORDS + 32'(word_r));
  assign w_waddr    = (in_data.req_type == REQ_WR_BIAS) ?
                      WADDR_W'(NUM_FEATURES * WORDS + 32'(in_word)) :
                      WADDR_W'(32'(in_data.add_feature_1) * WORDS + 32'(in_word));
  assign w_we       = accept && in_elem_ok &&
                      ((in_data.req_type == REQ_WR_WEIGHT && in_row_ok) ||
                       in_data.req_type == REQ_WR_BIAS);
  assign issue      = (state_r == ST_SWEEP) && slot_en_r[slot_r];

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    word_nxt  = word_r;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          slot_nxt = 2'd0;
          word_nxt = '0;
          if (in_data.req_type == REQ_READ) begin
            state_nxt = ST_FETCH;
          end else if (in_data.req_type == REQ_LOAD_BIAS ||
                       in_data.req_type == REQ_ADD_ROW ||
                       in_data.req_type == REQ_SUB_ROW ||
                       in_data.req_type == REQ_MOVE) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SWEEP: begin
        if (!slot_en_r[slot_r]) begin
          if (slot_r == 2'd3) begin
            state_nxt = ST_DONE;
          end else begin
            slot_nxt = slot_r + 2'd1;
          end
        end else begin
          word_nxt = word_r + WORD_W'(1);
          if (32'(word_r) == WORDS - 1) begin
            word_nxt  = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (slot_r == 2'd3) begin
          state_nxt = ST_DONE;
        end else begin
          slot_nxt  = slot_r + 2'd1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_FETCH: state_nxt = ST_DONE;
      ST_DONE: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      slot_r    <= 2'd0;
      word_r    <= '0;
      pv_r      <= 1'b0;
      acc_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      word_r  <= word_nxt;
      pv_r    <= issue;
      if (pv_r) begin
        acc_vld_r[pw_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    slot_en_nxt  = 4'b0000;
    slot_sub_nxt = 4'b0110;
    unique case (in_data.req_type)
      REQ_LOAD_BIAS: slot_en_nxt = 4'b0001;
      REQ_ADD_ROW:   slot_en_nxt = {3'b000, in_row_ok};
      REQ_SUB_ROW: begin
        slot_en_nxt  = {3'b000, in_row_ok};
        slot_sub_nxt = 4'b0001;
      end
      REQ_MOVE: begin
        slot_en_nxt[0] = in_row_ok;
        slot_en_nxt[1] = 32'(in_data.remove_feature_1) < NUM_FEATURES;
        slot_en_nxt[2] = (in_data.move_kind == MOVE_CAPTURE ||
                          in_data.move_kind == MOVE_CASTLE) &&
                         (32'(in_data.remove_feature_2) < NUM_FEATURES);
        slot_en_nxt[3] = (in_data.move_kind == MOVE_CASTLE) &&
                         (32'(in_data.add_feature_2) < NUM_FEATURES);
      end
      default: slot_en_nxt = 4'b0000;
    endcase
  end

  // Request capture: the four slots are the rows applied by this word, in slot order.
  always_ff @(posedge clk) begin
    if (accept) begin
      res_r.ack_type   <= in_data.req_type;
      res_r.read_value <= '0;
      lane_r           <= in_lane;
      elem_ok_r        <= in_elem_ok;
      copy_r           <= (in_data.req_type == REQ_LOAD_BIAS);
      slot_row_r[0]    <= (in_data.req_type == REQ_LOAD_BIAS) ? 10'(NUM_FEATURES) :
                          in_data.add_feature_1;
      slot_row_r[1]    <= in_data.remove_feature_1;
      slot_row_r[2]    <= in_data.remove_feature_2;
      slot_row_r[3]    <= in_data.add_feature_2;
      slot_sub_r       <= slot_sub_nxt;
      slot_en_r        <= slot_en_nxt;
    end else if (state_r == ST_FETCH) begin
      res_r.read_value <= (elem_ok_r && a_rdv_r) ? a_rd_r[32'(lane_r)*DW +: DW] : '0;
    end
  end

  always_ff @(posedge clk) begin
    pw_r        <= word_r;
    pctl_r.copy <= copy_r;
    pctl_r.sub  <= slot_sub_r[slot_r];
  end

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[w_waddr][32'(in_lane)*DW +: DW] <= in_data.write_value;
    end
    w_rd_r <= weight_mem[w_raddr];
  end

  // The drain cycle keeps the last write of a row ahead of the first read of the next.
  always_ff @(posedge clk) begin
    if (pv_r) begin
      acc_mem[pw_r] <= new_word;
    end
    a_rd_r  <= acc_mem[acc_raddr];
    a_rdv_r <= acc_vld_r[acc_raddr];
  end

  nau_lane_alu u_alu (
    .acc_word    (a_rdv_r ? a_rd_r : '0),
    .weight_word (w_rd_r),
    .bias_word   (w_rd_r),
    .ctrl        (pctl_r),
    .new_word    (new_word)
  );

  assign out_data = res_r;

  `NAU_ASSERT_NXT(a_strobe_single, clk, rst_n, out_valid, !out_valid)
  `NAU_ASSERT_NXT(a_busy_after_accept, clk, rst_n, accept, busy)
  `NAU_ASSERT_IMP(a_wb_in_sweep, clk, rst_n, pv_r, (state_r == ST_SWEEP || state_r == ST_DRAIN))
endmodule

// File: test/nnue_accumulator_update_unit_tb.sv
// Self-checking testbench for the accumulator update unit with its own accumulator predictor.
`timescale 1ns / 1ps
module nnue_accumulator_update_unit_tb;
  import nau_pkg::*;

  localparam logic [2:0] REQ_UNUSED  = 3'd7;
  localparam logic [1:0] MOVE_NORMAL = 2'd0;
  localparam logic [1:0] MOVE_SPARE  = 2'd3;
  localparam int         CYCLE_LIMIT = 2000000;
  localparam int         END_WAIT    = 300;
  localparam int         RANDOM_WORDS = 1050;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;

  nnue_accumulator_update_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // Predicted state of the block.
  bit [15:0] weight_mem [0:NUM_FEATURES*ACC_LEN-1];
  bit [15:0] bias_mem [0:ACC_LEN-1];
  bit [15:0] acc_mem [0:ACC_LEN-1];

  in_word_t  pending_words[$];
  out_word_t expected_acks[$];
  int        idle_left = 0;
  int        mismatches = 0;
  int        acks_seen = 0;
  int        kind_count [0:7];
  int        table_rows [0:3] = '{0, 341, 682, 767};

  task automatic apply_row(input logic [9:0] row, input bit subtract);
    int base;
    if (row >= NUM_FEATURES) return;
    base = int'(row) * ACC_LEN;
    for (int e = 0; e < ACC_LEN; e++)
      acc_mem[e] = subtract ? acc_mem[e] - weight_mem[base + e]
                            : acc_mem[e] + weight_mem[base + e];
  endtask

  task automatic predict_word(input in_word_t w, output out_word_t r);
    r.read_value = '0;
    r.ack_type   = w.req_type;
    case (w.req_type)
      REQ_WR_WEIGHT: begin
        if (w.add_feature_1 < NUM_FEATURES)
          weight_mem[int'(w.add_feature_1) * ACC_LEN + int'(w.element_index)] = w.write_value;
      end
      REQ_WR_BIAS: bias_mem[w.element_index] = w.write_value;
      REQ_LOAD_BIAS: acc_mem = bias_mem;
      REQ_ADD_ROW: apply_row(w.add_feature_1, 1'b0);
      REQ_SUB_ROW: apply_row(w.add_feature_1, 1'b1);
      REQ_MOVE: begin
        apply_row(w.add_feature_1, 1'b0);
        apply_row(w.remove_feature_1, 1'b1);
        if (w.move_kind == MOVE_CAPTURE) begin
          apply_row(w.remove_feature_2, 1'b1);
        end else if (w.move_kind == MOVE_CASTLE) begin
          apply_row(w.add_feature_2, 1'b0);
          apply_row(w.remove_feature_2, 1'b1);
        end
      end
      REQ_READ: r.read_value = acc_mem[w.element_index];
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // A row that has been written in full, or one past the end that the block ignores.
  function automatic logic [9:0] pick_row();
    if ($urandom_range(0, 99) < 85) return 10'(table_rows[$urandom_range(0, 3)]);
    return 10'($urandom_range(NUM_FEATURES, 1023));
  endfunction

  function automatic in_word_t noise_word(input logic [2:0] req);
    in_word_t w;
    w = in_word_t'({$urandom(), $urandom(), $urandom()});
    w.req_type = req;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int p;
    p = $urandom_range(0, 99);
    w = noise_word(REQ_READ);
    if (p < 14) w.req_type = REQ_WR_WEIGHT;
    else if (p < 24) w.req_type = REQ_WR_BIAS;
    else if (p < 29) w.req_type = REQ_LOAD_BIAS;
    else if (p < 43) w.req_type = REQ_ADD_ROW;
    else if (p < 57) w.req_type = REQ_SUB_ROW;
    else if (p < 83) w.req_type = REQ_MOVE;
    else if (p < 98) w.req_type = REQ_READ;
    else w.req_type = REQ_UNUSED;
    w.add_feature_1    = pick_row();
    w.add_feature_2    = pick_row();
    w.remove_feature_1 = pick_row();
    w.remove_feature_2 = pick_row();
    return w;
  endfunction

  // Driver: holds a word until it is accepted, then idles for a random gap.
  always @(posedge clk) begin
    out_word_t r;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_word(pending_words[0], r);
        expected_acks.push_back(r);
        kind_count[pending_words[0].req_type]++;
        void'(pending_words.pop_front());
        idle_left = pick_gap();
      end
      if (start && busy) begin
        // Hold the word until the block takes it.
      end else if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        start   <= 1'b1;
        in_data <= pending_words[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every result word is checked against the oldest prediction.
  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid) begin
      acks_seen++;
      if (expected_acks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: read_value %0d ack_type %0d",
                   out_data.read_value, out_data.ack_type);
      end else begin
        e = expected_acks.pop_front();
        if (e.read_value !== out_data.read_value || e.ack_type !== out_data.ack_type) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected read_value %0d ack_type %0d, got %0d %0d",
                     e.read_value, e.ack_type, out_data.read_value, out_data.ack_type);
        end
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    in_word_t w;
    foreach (kind_count[k]) kind_count[k] = 0;

    // The reset accumulator is zero, so it can be read before anything is written.
    w = noise_word(REQ_READ); w.element_index = 10'd0; pending_words.push_back(w);
    w = noise_word(REQ_UNUSED); pending_words.push_back(w);

    // Fill the bias and the rows in use so that no unwritten word is ever read.
    for (int e = 0; e < ACC_LEN; e++) begin
      w = noise_word(REQ_WR_BIAS); w.element_index = 10'(e); pending_words.push_back(w);
    end
    foreach (table_rows[i])
      for (int e = 0; e < ACC_LEN; e++) begin
        w = noise_word(REQ_WR_WEIGHT);
        w.add_feature_1 = 10'(table_rows[i]); w.element_index = 10'(e);
        pending_words.push_back(w);
      end

    // Directed part: extremes and the odd cases.
    w = noise_word(REQ_WR_WEIGHT); w.add_feature_1 = 10'd0; w.element_index = 10'd1023;
    w.write_value = 16'sh7FFF; pending_words.push_back(w);
    w = noise_word(REQ_WR_WEIGHT); w.add_feature_1 = 10'd767; w.element_index = 10'd1023;
    w.write_value = 16'sh8000; pending_words.push_back(w);
    w = noise_word(REQ_WR_WEIGHT); w.add_feature_1 = 10'd900; pending_words.push_back(w);
    w = noise_word(REQ_WR_BIAS); w.element_index = 10'd1023; w.write_value = 16'sh8000;
    pending_words.push_back(w);
    w = noise_word(REQ_LOAD_BIAS); pending_words.push_back(w);
    w = noise_word(REQ_READ); w.element_index = 10'd1023; pending_words.push_back(w);
    w = noise_word(REQ_ADD_ROW); w.add_feature_1 = 10'd0; pending_words.push_back(w);
    w = noise_word(REQ_SUB_ROW); w.add_feature_1 = 10'd767; pending_words.push_back(w);
    w = noise_word(REQ_ADD_ROW); w.add_feature_1 = 10'd1023; pending_words.push_back(w);
    w = noise_word(REQ_SUB_ROW); w.add_feature_1 = 10'd768; pending_words.push_back(w);
    w = noise_word(REQ_READ); w.element_index = 10'd1023; pending_words.push_back(w);
    for (int k = 0; k < 4; k++) begin
      w = noise_word(REQ_MOVE);
      w.move_kind = (k == 0) ? MOVE_NORMAL : (k == 1) ? MOVE_CAPTURE :
                    (k == 2) ? MOVE_CASTLE : MOVE_SPARE;
      w.add_feature_1 = 10'd341; w.add_feature_2 = 10'd682;
      w.remove_feature_1 = 10'd0; w.remove_feature_2 = (k == 3) ? 10'd1000 : 10'd767;
      pending_words.push_back(w);
      w = noise_word(REQ_READ); w.element_index = 10'($urandom_range(0, 1023));
      pending_words.push_back(w);
    end
    w = noise_word(REQ_UNUSED); pending_words.push_back(w);

    for (int n = 0; n < RANDOM_WORDS; n++) pending_words.push_back(random_word());

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || expected_acks.size() > 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);

    $display("covered %0d result words: %0d weight writes, %0d bias writes, %0d bias loads,",
             acks_seen, kind_count[REQ_WR_WEIGHT], kind_count[REQ_WR_BIAS],
             kind_count[REQ_LOAD_BIAS]);
    $display("  %0d row adds, %0d row subtracts, %0d moves, %0d reads, %0d unused requests",
             kind_count[REQ_ADD_ROW], kind_count[REQ_SUB_ROW], kind_count[REQ_MOVE],
             kind_count[REQ_READ], kind_count[REQ_UNUSED]);
    if (mismatches == 0 && expected_acks.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
